@@ hdl/pfcrc_pkg.sv @@
// Shared types, constants and CRC-16 helpers for the packet framer.
package pfcrc_pkg;

    // Input beat: one payload byte with its packet marks
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] packet_type;
        logic       first_flag;
        logic       last_flag;
    } item_t;

    // Output beat: one byte toward the serial line
    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
    } line_t;

    // Position within the byte sequence one input beat produces
    typedef enum logic [2:0] {
        SL_SYNC1,
        SL_SYNC2,
        SL_TYPE,
        SL_DATA,
        SL_CRC_LO,
        SL_CRC_HI
    } slot_t;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    // Nibble lookup: CRC-16 (0x1021) remainder of a 4-bit index
    function automatic logic [15:0] nib_table(input logic [3:0] idx);
        logic [15:0] val;
        begin
            case (idx)
                4'h0:    val = 16'h0000;
                4'h1:    val = 16'h1021;
                4'h2:    val = 16'h2042;
                4'h3:    val = 16'h3063;
                4'h4:    val = 16'h4084;
                4'h5:    val = 16'h50A5;
                4'h6:    val = 16'h60C6;
                4'h7:    val = 16'h70E7;
                4'h8:    val = 16'h8108;
                4'h9:    val = 16'h9129;
                4'hA:    val = 16'hA14A;
                4'hB:    val = 16'hB16B;
                4'hC:    val = 16'hC18C;
                4'hD:    val = 16'hD1AD;
                4'hE:    val = 16'hE1CE;
                4'hF:    val = 16'hF1EF;
                default: val = 16'h0000;
            endcase
            return val;
        end
    endfunction

    // Fold one nibble into the CRC, MSB first
    function automatic logic [15:0] fold_nibble(input logic [15:0] crc,
                                                input logic [3:0]  nib);
        logic [15:0] shifted;
        begin
            shifted = {crc[11:0], 4'h0};
            return shifted ^ nib_table(crc[15:12] ^ nib);
        end
    endfunction

    // Fold a whole byte, high nibble first
    function automatic logic [15:0] fold_byte(input logic [15:0] crc,
                                              input logic [7:0]  b);
        logic [15:0] mid;
        begin
            mid = fold_nibble(crc, b[7:4]);
            return fold_nibble(mid, b[3:0]);
        end
    endfunction

endpackage

@@ hdl/pfcrc_crc.sv @@
// CRC seed register and running CRC-16 accumulator.
module pfcrc_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_wr,
    input  logic [15:0] seed_data,
    input  logic        fold,
    input  logic        first,
    input  logic [7:0]  data,
    output logic [15:0] crc_folded
);

    logic [15:0] seed_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_base;

    // Seed register, written from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_wr)
        begin
            seed_reg <= seed_data;
        end
    end

    // A first byte restarts from the seed
    assign crc_base   = first ? seed_reg : crc_reg;
    assign crc_folded = pfcrc_pkg::fold_byte(crc_base, data);

    // Running CRC advances once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else if (fold)
        begin
            crc_reg <= crc_folded;
        end
    end

endmodule

@@ hdl/packet_framer_crc16.sv @@
// Top level of the byte packet framer with CRC-16 trailer.
// Takes one payload byte per beat and sends bytes toward the line, one per
// output beat. A plain payload byte yields one line byte; a byte marked
// first is preceded by 0xAA, 0x55 and the packet type; a byte marked last
// is followed by the CRC low byte and then the CRC high byte, which carries
// frame_end. The CRC (polynomial 0x1021, MSB first) is loaded from the seed
// register on each first byte. An input beat therefore yields 1 to 6 line
// bytes through the single-byte output register: 1 + 3*first + 2*last, so
// plain payload bytes stream at one per cycle with the line not
// stalling. The input register takes the next beat in the cycle its final
// line byte moves into the output register. The seed port is always ready.
module packet_framer_crc16 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seed_valid,
    output logic                seed_ready,
    input  logic [15:0]         seed,
    input  logic                item_valid,
    output logic                item_stall,
    input  pfcrc_pkg::item_t    item,
    output logic                line_valid,
    input  logic                line_stall,
    output pfcrc_pkg::line_t    line
);

    pfcrc_pkg::item_t  stage_reg;
    logic [15:0]       crc_reg;
    logic              stage_valid_reg;
    pfcrc_pkg::slot_t  slot_reg;
    pfcrc_pkg::slot_t  slot_next;
    logic              line_valid_reg;
    pfcrc_pkg::line_t  line_reg;
    pfcrc_pkg::line_t  line_next;
    logic [15:0]       crc_folded;
    logic              item_acc;
    logic              emit;
    logic              stage_final;

    assign seed_ready = 1'b1;

    // CRC accumulator
    pfcrc_crc u_crc (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_wr    (seed_valid & seed_ready),
        .seed_data  (seed),
        .fold       (item_acc),
        .first      (item.first_flag),
        .data       (item.payload_byte),
        .crc_folded (crc_folded)
    );

    // Handshake control
    assign emit        = stage_valid_reg & (~line_valid_reg | ~line_stall);
    assign stage_final = (slot_reg == pfcrc_pkg::SL_CRC_HI) |
                         ((slot_reg == pfcrc_pkg::SL_DATA) & ~stage_reg.last_flag);
    assign item_stall  = stage_valid_reg & ~(emit & stage_final);
    assign item_acc    = item_valid & ~item_stall;

    // Next slot within the current beat's byte sequence
    always_comb
    begin
        case (slot_reg)
            pfcrc_pkg::SL_SYNC1:  slot_next = pfcrc_pkg::SL_SYNC2;
            pfcrc_pkg::SL_SYNC2:  slot_next = pfcrc_pkg::SL_TYPE;
            pfcrc_pkg::SL_TYPE:   slot_next = pfcrc_pkg::SL_DATA;
            pfcrc_pkg::SL_DATA:   slot_next = pfcrc_pkg::SL_CRC_LO;
            pfcrc_pkg::SL_CRC_LO: slot_next = pfcrc_pkg::SL_CRC_HI;
            default:              slot_next = pfcrc_pkg::SL_CRC_HI;
        endcase
    end

    // Line byte for the current slot
    always_comb
    begin
        line_next.frame_end = 1'b0;
        case (slot_reg)
            pfcrc_pkg::SL_SYNC1:  line_next.line_byte = pfcrc_pkg::SYNC_FIRST;
            pfcrc_pkg::SL_SYNC2:  line_next.line_byte = pfcrc_pkg::SYNC_SECOND;
            pfcrc_pkg::SL_TYPE:   line_next.line_byte = stage_reg.packet_type;
            pfcrc_pkg::SL_DATA:   line_next.line_byte = stage_reg.payload_byte;
            pfcrc_pkg::SL_CRC_LO: line_next.line_byte = crc_reg[7:0];
            pfcrc_pkg::SL_CRC_HI:
            begin
                line_next.line_byte = crc_reg[15:8];
                line_next.frame_end = 1'b1;
            end
            default:              line_next.line_byte = stage_reg.payload_byte;
        endcase
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            slot_reg        <= pfcrc_pkg::SL_DATA;
        end
        else if (item_acc)
        begin
            stage_valid_reg <= 1'b1;
            slot_reg        <= item.first_flag ? pfcrc_pkg::SL_SYNC1 : pfcrc_pkg::SL_DATA;
        end
        else if (emit)
        begin
            stage_valid_reg <= ~stage_final;
            slot_reg        <= slot_next;
        end
    end

    // Input register payload, with the CRC after this byte
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            stage_reg <= item;
            crc_reg   <= crc_folded;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            line_valid_reg <= 1'b1;
        end
        else if (!line_stall)
        begin
            line_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            line_reg <= line_next;
        end
    end

    assign line_valid = line_valid_reg;
    assign line       = line_reg;

    // A first byte always opens with the sync sequence
    a_first_starts_sync: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc && item.first_flag |=> stage_valid_reg && slot_reg == pfcrc_pkg::SL_SYNC1)
        else $error("first byte did not start at sync slot");

    // Emitting the CRC high byte presents frame_end on the line
    a_crc_hi_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        emit && slot_reg == pfcrc_pkg::SL_CRC_HI |=> line_valid_reg && line_reg.frame_end)
        else $error("CRC high byte without frame_end");

    // CRC slots only occur for a last byte
    a_crc_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && (slot_reg == pfcrc_pkg::SL_CRC_LO ||
                            slot_reg == pfcrc_pkg::SL_CRC_HI) |-> stage_reg.last_flag)
        else $error("CRC slot reached for a byte not marked last");

    // frame_end only appears on a valid beat that came from the CRC high slot
    a_end_from_crc_hi: assert property (@(posedge clk) disable iff (!rst_n)
        emit && slot_reg != pfcrc_pkg::SL_CRC_HI |=> !line_reg.frame_end)
        else $error("frame_end on a byte other than the CRC high byte");

endmodule
